>>> src/tobl_pkg.sv
package tobl_pkg;

	localparam int NUM_INSTR = 32;

	localparam logic [2:0] ST_ACCEPT    = 3'd0;
	localparam logic [2:0] ST_NOTIONAL  = 3'd1;
	localparam logic [2:0] ST_TICK      = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_NODATA    = 3'd4;
	localparam logic [2:0] ST_MALFORMED = 3'd5;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	// Inverse of an odd number modulo 2^40 by Newton iteration.
	function automatic logic [39:0] odd_inv40(input logic [39:0] d);
		logic [39:0] x;
		x = d;
		for (int k = 0; k < 5; k++)
			x = x * (40'd2 - d * x);
		return x;
	endfunction

	// A 40-bit value is a multiple of d when value * inv(d) stays at or below LIM.
	localparam logic [39:0] INV25  = odd_inv40(40'd25);
	localparam logic [39:0] INV125 = odd_inv40(40'd125);
	localparam logic [39:0] LIM25  = 40'hFF_FFFF_FFFF / 40'd25;
	localparam logic [39:0] LIM125 = 40'hFF_FFFF_FFFF / 40'd125;

	// Book state held by one cell.
	typedef struct packed {
		logic        used;
		logic [63:0] code;
		logic        has_bid;
		logic        has_ask;
		logic [39:0] bid_best;
		logic [39:0] ask_best;
		logic [31:0] bid_cnt;
		logic [31:0] ask_cnt;
	} entry_t;

	// Row update broadcast to every cell.
	typedef struct packed {
		logic        upd;
		logic        alloc;
		logic [63:0] code;
		logic        sell;
		logic        nz;
		logic [39:0] price;
	} row_cmd_t;

	function automatic logic [2:0] status_rank(input logic [2:0] s);
		unique case (s)
			ST_NOTIONAL:  status_rank = 3'd1;
			ST_TICK:      status_rank = 3'd2;
			ST_FULL:      status_rank = 3'd3;
			ST_MALFORMED: status_rank = 3'd4;
			default:      status_rank = 3'd0;
		endcase
	endfunction

endpackage

>>> src/tobl_cell.sv
module tobl_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  tobl_pkg::row_cmd_t cmd,
	input  logic               shl,
	input  tobl_pkg::entry_t   lft,
	input  tobl_pkg::entry_t   rgt,
	input  logic               lft_gt,
	output tobl_pkg::entry_t   ent,
	output logic               hit,
	output logic               gt
);
	import tobl_pkg::*;

	entry_t ent_q;
	logic   used_q;
	logic   ins;

	assign ent = '{used: used_q, code: ent_q.code, has_bid: ent_q.has_bid,
		has_ask: ent_q.has_ask, bid_best: ent_q.bid_best, ask_best: ent_q.ask_best,
		bid_cnt: ent_q.bid_cnt, ask_cnt: ent_q.ask_cnt};
	assign hit = used_q && (ent_q.code == cmd.code);
	// Cells at or past the insert point of the row's code.
	assign gt  = !used_q || (ent_q.code > cmd.code);
	assign ins = cmd.upd && cmd.alloc;

	// Valid bit: shift left during report, shift right or set on insert.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (shl) begin
			used_q <= rgt.used;
		end else if (ins && lft_gt) begin
			used_q <= lft.used;
		end else if (ins && gt) begin
			used_q <= 1'b1;
		end
	end

	// Payload: take a neighbor's word, insert a new code, or update best and counts.
	always_ff @(posedge clk) begin
		priority if (shl) begin
			ent_q <= rgt;
		end else if (ins && lft_gt) begin
			ent_q <= lft;
		end else if (ins && gt) begin
			ent_q.code     <= cmd.code;
			ent_q.has_bid  <= cmd.nz && !cmd.sell;
			ent_q.has_ask  <= cmd.nz && cmd.sell;
			ent_q.bid_best <= (cmd.nz && !cmd.sell) ? cmd.price : 40'd0;
			ent_q.ask_best <= (cmd.nz && cmd.sell) ? cmd.price : 40'd0;
			ent_q.bid_cnt  <= {31'd0, cmd.nz && !cmd.sell};
			ent_q.ask_cnt  <= {31'd0, cmd.nz && cmd.sell};
		end else if (cmd.upd && !cmd.alloc && hit) begin
			if (cmd.nz && !cmd.sell) begin
				if (ent_q.bid_cnt != CNT_MAX) ent_q.bid_cnt <= ent_q.bid_cnt + 32'd1;
				if (!ent_q.has_bid || cmd.price > ent_q.bid_best) begin
					ent_q.bid_best <= cmd.price;
					ent_q.has_bid  <= 1'b1;
				end
			end else if (cmd.nz) begin
				if (ent_q.ask_cnt != CNT_MAX) ent_q.ask_cnt <= ent_q.ask_cnt + 32'd1;
				if (!ent_q.has_ask || cmd.price < ent_q.ask_best) begin
					ent_q.ask_best <= cmd.price;
					ent_q.has_ask  <= 1'b1;
				end
			end
		end
	end
endmodule

>>> src/tobl_notional.sv
module tobl_notional (
	input  logic        clk,
	input  logic [39:0] price,
	input  logic [31:0] qty,
	input  logic [62:0] max_notional,
	output logic        over
);
	// Split product into two 20x32 partial products, registered.
	logic [51:0] lo_s1, hi_s1;
	logic [62:0] lim_s1;

	always_ff @(posedge clk) begin
		lo_s1  <= {32'd0, price[19:0]} * {20'd0, qty};
		hi_s1  <= {32'd0, price[39:20]} * {20'd0, qty};
		lim_s1 <= max_notional;
	end

	logic [72:0] prod;
	assign prod = {21'd0, lo_s1} + {1'b0, hi_s1, 20'd0};
	assign over = (prod > {10'd0, lim_s1});
endmodule

>>> src/top_of_book_ladder_builder_top.sv
// Channel | Dir | Handshake           | Word
// input   | in  | in_valid/in_stall   | one book row or finish
// output  | out | out_valid/out_stall | one report entry
// config  | in  | cfg_we              | max_notional, written at once
// A book row is accepted (product and tick partials registered), then the key match
// across the cells and table update follow; a malformed row finishes at accept.
// A finish gives one report word per entry (at least one word): the cells keep
// codes in ascending order and each report word shifts the chain left by one cell.
// A stalled report word waits in the output register and holds the chain.
// Reset clears the valid bits and sticky state and loads the limit with 2^63-1.
module top_of_book_ladder_builder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [63:0] sym_code,
	input  logic        is_sell,
	input  logic [15:0] level_count,
	input  logic [39:0] price,
	input  logic [31:0] quantity,
	input  logic [15:0] order_count,
	input  logic        cfg_we,
	input  logic [62:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] code_out,
	output logic [31:0] bid_depth,
	output logic [31:0] ask_depth,
	output logic [1:0]  generation,
	output logic        invalid,
	output logic [39:0] top_bid,
	output logic [39:0] top_ask,
	output logic [2:0]  status,
	output logic        level_warning,
	output logic        order_warning,
	output logic        last
);
	import tobl_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ROW  = 2'd1;
	localparam logic [1:0] S_REP  = 2'd2;

	logic [1:0]  state_q;
	logic [62:0] max_q;
	logic [63:0] code_q;
	logic        sell_q;
	logic [39:0] price_q;
	logic [31:0] qty_q;
	logic [2:0]  sticky_q;
	logic        lvl_q, ord_q, seen_q;
	logic [2:0]  rep_st_q;

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_q <= 63'h7FFF_FFFF_FFFF_FFFF;
		else if (cfg_we) max_q <= cfg_data;
	end

	// Notional product unit, one register deep.
	logic over;
	tobl_notional u_notional (.clk(clk), .price(price), .qty(quantity),
		.max_notional(max_q), .over(over));

	// Tick partial products: 100 = 4*25, 500 = 4*125, 1000 = 8*125.
	logic [39:0] ll25_s1, ll125_s1;
	logic [19:0] mid25_s1, mid125_s1;
	always_ff @(posedge clk) begin
		ll25_s1   <= {20'd0, price[19:0]} * {20'd0, INV25[19:0]};
		mid25_s1  <= 20'(price[39:20] * INV25[19:0]) + 20'(price[19:0] * INV25[39:20]);
		ll125_s1  <= {20'd0, price[19:0]} * {20'd0, INV125[19:0]};
		mid125_s1 <= 20'(price[39:20] * INV125[19:0]) + 20'(price[19:0] * INV125[39:20]);
	end

	logic [39:0] q25, q125;
	logic        div25, div125;
	assign q25    = ll25_s1 + {mid25_s1, 20'd0};
	assign q125   = ll125_s1 + {mid125_s1, 20'd0};
	assign div25  = (q25 <= LIM25);
	assign div125 = (q125 <= LIM125);

	// Chain of cells, kept sorted by code; insert shifts right, report shifts left.
	entry_t   ents  [NUM_INSTR];
	entry_t   nbr_l [NUM_INSTR];
	entry_t   nbr_r [NUM_INSTR];
	logic [NUM_INSTR-1:0] hits, gts, lgts;
	row_cmd_t cmd;
	logic     shl;

	genvar g;
	generate
		for (g = 0; g < NUM_INSTR; g++) begin : g_cell
			if (g == 0) begin : g_first
				assign nbr_l[g] = '0;
				assign lgts[g]  = 1'b0;
			end else begin : g_after
				assign nbr_l[g] = ents[g-1];
				assign lgts[g]  = gts[g-1];
			end
			if (g == NUM_INSTR - 1) begin : g_end
				assign nbr_r[g] = '0;
			end else begin : g_mid
				assign nbr_r[g] = ents[g+1];
			end
			tobl_cell u_cell (.clk(clk), .arst_n(arst_n), .cmd(cmd), .shl(shl),
				.lft(nbr_l[g]), .rgt(nbr_r[g]), .lft_gt(lgts[g]),
				.ent(ents[g]), .hit(hits[g]), .gt(gts[g]));
		end
	endgenerate

	// Match and fullness; used cells form a prefix of the chain.
	logic any_hit, full;
	assign any_hit = |hits;
	assign full    = ents[NUM_INSTR-1].used;

	// Row checks in the cycle after accept.
	logic [2:0]  tick_st, row_st;
	logic [7:0]  c0;
	logic        tick_bad;
	assign c0 = code_q[63:56];
	always_comb begin
		if (c0 >= "1" && c0 <= "3")      tick_bad = !(price_q[1:0] == 2'd0 && div25);
		else if (c0 >= "4" && c0 <= "7") tick_bad = !(price_q[1:0] == 2'd0 && div125);
		else                              tick_bad = !(price_q[2:0] == 3'd0 && div125);
		tick_st = tick_bad ? ST_TICK : ((qty_q != 32'd0 && over) ? ST_NOTIONAL : ST_ACCEPT);
		row_st  = (!any_hit && full) ? ST_FULL : tick_st;
	end

	always_comb begin
		cmd.upd   = (state_q == S_ROW) && (any_hit || !full);
		cmd.alloc = !any_hit;
		cmd.code  = code_q;
		cmd.sell  = sell_q;
		cmd.nz    = (qty_q != 32'd0);
		cmd.price = price_q;
	end

	// Report: cell 0 holds the lowest code left.
	logic emit, any_left, last_w;
	assign emit     = (state_q == S_REP) && (!out_valid || out_acc);
	assign shl      = emit;
	assign any_left = ents[0].used;
	assign last_w   = !nbr_r[0].used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; sticky_q <= ST_ACCEPT;
			lvl_q <= 1'b0; ord_q <= 1'b0; seen_q <= 1'b0; out_valid <= 1'b0;
			rep_st_q <= ST_ACCEPT;
		end else begin
			if (emit) out_valid <= 1'b1;
			else if (out_acc) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_acc) begin
					if (func) begin
						state_q  <= S_REP;
						rep_st_q <= seen_q ? sticky_q : ST_NODATA;
					end else begin
						seen_q <= 1'b1;
						if (price == 40'd0) begin
							if (status_rank(ST_MALFORMED) > status_rank(sticky_q))
								sticky_q <= ST_MALFORMED;
						end else begin
							state_q <= S_ROW;
							if (level_count == 16'd0 && (quantity != 32'd0 || order_count != 16'd0))
								lvl_q <= 1'b1;
							if ((quantity == 32'd0) != (order_count == 16'd0))
								ord_q <= 1'b1;
						end
					end
				end
				S_ROW: begin
					state_q <= S_IDLE;
					if (status_rank(row_st) > status_rank(sticky_q)) sticky_q <= row_st;
				end
				S_REP: if (emit && last_w) begin
					state_q <= S_IDLE; sticky_q <= ST_ACCEPT;
					lvl_q <= 1'b0; ord_q <= 1'b0; seen_q <= 1'b0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			code_q <= sym_code; sell_q <= is_sell; price_q <= price; qty_q <= quantity;
		end
	end

	// Output word register.
	logic bad;
	assign bad = !ents[0].has_bid || !ents[0].has_ask
		|| ents[0].bid_best >= ents[0].ask_best;
	always_ff @(posedge clk) begin
		if (emit) begin
			status        <= rep_st_q;
			level_warning <= lvl_q;
			order_warning <= ord_q;
			last          <= last_w;
			if (!any_left) begin
				code_out <= '0; bid_depth <= '0; ask_depth <= '0; generation <= 2'd0;
				invalid <= 1'b0; top_bid <= '0; top_ask <= '0;
			end else begin
				code_out   <= ents[0].code;
				bid_depth  <= ents[0].bid_cnt;
				ask_depth  <= ents[0].ask_cnt;
				generation <= bad ? 2'd2 : 2'd1;
				invalid    <= bad;
				top_bid    <= bad ? 40'd0 : ents[0].bid_best;
				top_ask    <= bad ? 40'd0 : ents[0].ask_best;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_w) |=> (out_valid && last)) else $error("report end lost");
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW) |-> $onehot0(hits)) else $error("duplicate code");
`endif
endmodule
